FILE: design/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared constants, codes and the symbol mapping of the symbol frequency
// histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

  // Default geometry of the counter tables
  localparam int DEF_BINS        = 4096;
  localparam int DEF_COUNT_WIDTH = 32;
  localparam int DEF_AXES        = 3;

  // Fixed field widths
  localparam int FIELD_AXES    = 3;
  localparam int SAMPLE_WIDTH  = 12;
  localparam int NUMBER_WIDTH  = 32;
  localparam int BIN_WIDTH     = 12;
  localparam int TOTAL_WIDTH   = 32;
  localparam int SYMBOL_WIDTH  = 16;
  localparam int DELTA_WIDTH   = 14;
  localparam int DATA_WIDTH    = 80;

  // Operation codes (carried on tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Configuration register indexes
  localparam int   CFG_INDEX_WIDTH     = 1;
  localparam int   CFG_DATA_WIDTH      = 1;
  localparam logic CFG_DIFFERENCE_MODE = 1'b0;
  localparam logic CFG_WHOLE_SYMBOLS   = 1'b1;

  // Offset added to a difference so it lands in the positive range
  localparam logic [DELTA_WIDTH-1:0] DELTA_OFFSET = 14'd4096;

  // Map one axis value (and its previous value) to a 16-bit symbol.
  // Whole mode: 12-bit symbol; byte mode: 16-bit word split into bytes later.
  function automatic logic [SYMBOL_WIDTH-1:0] symbol_of(
    input logic [SAMPLE_WIDTH-1:0] value,
    input logic [SAMPLE_WIDTH-1:0] prev,
    input logic                    diff,
    input logic                    whole
  );
    logic [DELTA_WIDTH-1:0]  delta;
    logic [SYMBOL_WIDTH-1:0] sym;
    delta = {{2{value[SAMPLE_WIDTH-1]}}, value} - {{2{prev[SAMPLE_WIDTH-1]}}, prev}
            + DELTA_OFFSET;
    if (whole) begin
      if (diff) sym = {4'b0000, delta[SAMPLE_WIDTH-1:0]};
      else      sym = {4'b0000, ~value[SAMPLE_WIDTH-1], value[SAMPLE_WIDTH-2:0]};
    end else begin
      if (diff) sym = {2'b00, delta};
      else      sym = {{4{value[SAMPLE_WIDTH-1]}}, value};
    end
    return sym;
  endfunction

endpackage

`default_nettype wire

FILE: design/symbol_frequency_histogram.sv
// ----------------------------------------------------------------------------
// symbol_frequency_histogram
// Per-axis symbol frequency counters for Huffman table generation, with a
// summed read-out of one bin.
// ----------------------------------------------------------------------------
// After reset the block sweeps all tables to zero, one bin per cycle, while
// s_tready stays low (configuration writes are taken at any time). Items are
// handled one at a time. Each counter update is a read-modify-write on the
// axis table (one read port, one write port, registered read data), so a
// counted sample passes through ST_FIRST in whole-symbol mode and through
// ST_FIRST and then ST_SECOND in byte mode, where the high-byte update follows
// the low-byte update and picks up its result by forwarding when both hit the
// same bin. A sample that is not counted goes straight back to ST_IDLE. A
// read waits in ST_READ for the output register; the result sits in that
// register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_frequency_histogram #(
  parameter int BINS        = sfh_pkg::DEF_BINS,
  parameter int COUNT_WIDTH = sfh_pkg::DEF_COUNT_WIDTH,
  parameter int AXES        = sfh_pkg::DEF_AXES
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [sfh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [sfh_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: sample_number[31:0], axis_x[43:32], axis_y[55:44],
  //          axis_z[67:56], bin_index[79:68]
  input  logic [sfh_pkg::DATA_WIDTH-1:0]      s_tdata,
  // s_tuser: operation[0]
  input  logic                                s_tuser,
  // output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: bin_total[31:0]
  output logic [sfh_pkg::TOTAL_WIDTH-1:0]     m_tdata
);

  localparam int AW   = $clog2(BINS);
  localparam int CW   = COUNT_WIDTH;
  localparam int TW   = sfh_pkg::TOTAL_WIDTH;
  localparam int SW   = sfh_pkg::SAMPLE_WIDTH;
  localparam int NW   = sfh_pkg::NUMBER_WIDTH;
  localparam int BW   = sfh_pkg::BIN_WIDTH;
  localparam int YW   = sfh_pkg::SYMBOL_WIDTH;
  localparam int FA   = sfh_pkg::FIELD_AXES;
  localparam int USED = (AXES < FA) ? AXES : FA;
  localparam int CMPW = YW + 1;

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FIRST  = 3'd2;
  localparam logic [2:0] ST_SECOND = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] clear_addr;

  // configuration and previous sample
  logic          difference_mode;
  logic          whole_symbols;
  logic          have_previous;
  logic [NW-1:0] previous_number;
  logic [SW-1:0] previous_values [FA];

  // input fields
  logic [NW-1:0] sample_number;
  logic [SW-1:0] axis_value [FA];
  logic [BW-1:0] bin_index;
  logic          in_xfer;
  logic          counted;
  logic          bin_ok;

  assign sample_number = s_tdata[NW-1:0];
  assign axis_value[0] = s_tdata[NW +:      SW];
  assign axis_value[1] = s_tdata[NW + SW +: SW];
  assign axis_value[2] = s_tdata[NW + 2*SW +: SW];
  assign bin_index     = s_tdata[NW + 3*SW +: BW];

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  assign counted = have_previous &&
                   (!difference_mode || (previous_number + NW'(1)) == sample_number);
  assign bin_ok  = {{(CMPW-BW){1'b0}}, bin_index} < CMPW'(BINS);

  // per-axis lanes: symbols, addresses, update enables
  logic [AXES-1:0][AW-1:0] first_addr;
  logic [AXES-1:0][AW-1:0] second_addr;
  logic [AXES-1:0]         first_en_next;
  logic [AXES-1:0]         second_en_next;

  logic [AXES-1:0][AW-1:0] lo_addr;
  logic [AXES-1:0][AW-1:0] hi_addr;
  logic [AXES-1:0]         lo_en;
  logic [AXES-1:0]         hi_en;
  logic [AXES-1:0][CW-1:0] fwd_count;
  logic                    second_pending;
  logic                    read_bin_ok;

  logic [AXES-1:0]         tbl_we;
  logic [AXES-1:0][AW-1:0] tbl_waddr;
  logic [AXES-1:0][CW-1:0] tbl_wdata;
  logic                    tbl_re;
  logic [AXES-1:0][AW-1:0] tbl_raddr;
  logic [AXES-1:0][CW-1:0] tbl_rdata;

  genvar g;
  generate
    for (g = 0; g < AXES; g++) begin : g_axis
      if (g < USED) begin : g_lane
        logic [YW-1:0] sym;
        logic          fits;
        assign sym  = sfh_pkg::symbol_of(axis_value[g], previous_values[g],
                                         difference_mode, whole_symbols);
        assign fits = !whole_symbols || ({1'b0, sym} < CMPW'(BINS));
        assign first_addr[g]     = whole_symbols ? AW'(sym) : AW'(sym[7:0]);
        assign second_addr[g]    = AW'(sym[YW-1:8]);
        assign first_en_next[g]  = counted && fits;
        assign second_en_next[g] = counted && !whole_symbols;
      end else begin : g_spare
        assign first_addr[g]     = '0;
        assign second_addr[g]    = '0;
        assign first_en_next[g]  = 1'b0;
        assign second_en_next[g] = 1'b0;
      end

      // table ports: clear sweep, then read-modify-write updates
      always_comb begin
        logic [CW-1:0] base;
        base = (lo_en[g] && (hi_addr[g] == lo_addr[g])) ? fwd_count[g] : tbl_rdata[g];
        tbl_we[g]    = 1'b0;
        tbl_waddr[g] = hi_addr[g];
        tbl_wdata[g] = base + CW'(1);
        unique case (state)
          ST_CLEAR: begin
            tbl_we[g]    = 1'b1;
            tbl_waddr[g] = clear_addr;
            tbl_wdata[g] = '0;
          end
          ST_FIRST: begin
            tbl_we[g]    = lo_en[g];
            tbl_waddr[g] = lo_addr[g];
            tbl_wdata[g] = tbl_rdata[g] + CW'(1);
          end
          ST_SECOND: tbl_we[g] = hi_en[g];
          default:   tbl_we[g] = 1'b0;
        endcase
        if (state == ST_IDLE) begin
          tbl_raddr[g] = (s_tuser == sfh_pkg::OP_READ) ? AW'(bin_index) : first_addr[g];
        end else begin
          tbl_raddr[g] = hi_addr[g];
        end
      end

      sfh_table #(
        .DEPTH (BINS),
        .WIDTH (CW),
        .AW    (AW)
      ) u_table (
        .clk   (clk),
        .we    (tbl_we[g]),
        .waddr (tbl_waddr[g]),
        .wdata (tbl_wdata[g]),
        .re    (tbl_re),
        .raddr (tbl_raddr[g]),
        .rdata (tbl_rdata[g])
      );
    end
  endgenerate

  assign tbl_re = in_xfer || (state == ST_FIRST && second_pending);

  // summed read-out of one bin
  logic [TW-1:0] bin_sum;
  logic          out_load;

  always_comb begin
    bin_sum = '0;
    for (int a = 0; a < AXES; a++) begin
      bin_sum = bin_sum + TW'(tbl_rdata[a]);
    end
    if (!read_bin_ok) bin_sum = '0;
  end

  assign out_load = (state == ST_READ) && (!m_tvalid || m_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      difference_mode <= 1'b0;
      whole_symbols   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfh_pkg::CFG_DIFFERENCE_MODE: difference_mode <= cfg_data[0];
        sfh_pkg::CFG_WHOLE_SYMBOLS:   whole_symbols   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clear_addr    <= '0;
      have_previous <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(BINS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_tuser == sfh_pkg::OP_READ) begin
              state <= ST_READ;
            end else begin
              have_previous <= 1'b1;
              if (counted) state <= ST_FIRST;
            end
          end
        end
        ST_FIRST:  state <= second_pending ? ST_SECOND : ST_IDLE;
        ST_SECOND: state <= ST_IDLE;
        ST_READ:   if (out_load) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // previous sample and per-item update plan
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_number <= '0;
      for (int a = 0; a < FA; a++) previous_values[a] <= '0;
    end else if (in_xfer && s_tuser == sfh_pkg::OP_SAMPLE) begin
      previous_number <= sample_number;
      for (int a = 0; a < FA; a++) previous_values[a] <= axis_value[a];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lo_addr        <= first_addr;
      hi_addr        <= second_addr;
      lo_en          <= first_en_next;
      hi_en          <= second_en_next;
      second_pending <= counted && !whole_symbols;
      read_bin_ok    <= bin_ok;
    end
    // low-byte result, forwarded when the high byte hits the same bin
    if (state == ST_FIRST) begin
      for (int a = 0; a < AXES; a++) fwd_count[a] <= tbl_rdata[a] + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= bin_sum;
  end

endmodule

`default_nettype wire

FILE: design/sfh_table.sv
// ----------------------------------------------------------------------------
// sfh_table
// Counter table of one axis: one write port, one read port, registered read
// data (old data on a read of the entry being written).
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_table #(
  parameter int DEPTH = sfh_pkg::DEF_BINS,
  parameter int WIDTH = sfh_pkg::DEF_COUNT_WIDTH,
  parameter int AW    = $clog2(sfh_pkg::DEF_BINS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/tb_symbol_frequency_histogram.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_symbol_frequency_histogram
// Self-checking bench for the three-axis symbol frequency histogram. Sample
// and read transfers go in over the slave stream, bin totals come back over
// the master stream. A scoreboard keeps its own copy of the axis tables and
// the previous sample, predicts every bin total and checks the results in
// order. The run covers all four counting modes, number gaps and wraps,
// value extremes, and random sender bursts against random receiver stalls.
// ----------------------------------------------------------------------------

module tb_symbol_frequency_histogram;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  // covers the table clearing sweep after reset plus the worst stall
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 32;
  localparam int PHASE_ITEMS   = 125;
  localparam int RANDOM_PHASES = 10;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_STARVE} rx_mode_t;

  // Keeps a shadow of the axis tables and predicts the bin totals
  class hist_scoreboard;
    bit [sfh_pkg::TOTAL_WIDTH-1:0]  counts[sfh_pkg::DEF_AXES][sfh_pkg::DEF_BINS];
    bit                             have_prev;
    bit [sfh_pkg::NUMBER_WIDTH-1:0] prev_number;
    bit [sfh_pkg::SAMPLE_WIDTH-1:0] prev_value[sfh_pkg::FIELD_AXES];
    bit                             diff_mode;
    bit                             whole_mode;
    bit [sfh_pkg::TOTAL_WIDTH-1:0]  totals_q[$];
    int                             errors;

    function void set_modes(bit diff, bit whole);
      diff_mode  = diff;
      whole_mode = whole;
    endfunction

    function int pending();
      return totals_q.size();
    endfunction

    function void bump(int axis, int sym);
      if (sym < sfh_pkg::DEF_BINS) counts[axis][sym] = counts[axis][sym] + 1'b1;
    endfunction

    // Update the shadow tables for one accepted input transfer
    function void note_input(bit op, bit [sfh_pkg::NUMBER_WIDTH-1:0] number,
                             bit [sfh_pkg::SAMPLE_WIDTH-1:0] x,
                             bit [sfh_pkg::SAMPLE_WIDTH-1:0] y,
                             bit [sfh_pkg::SAMPLE_WIDTH-1:0] z,
                             bit [sfh_pkg::BIN_WIDTH-1:0] bin);
      bit [sfh_pkg::SAMPLE_WIDTH-1:0] vals[sfh_pkg::FIELD_AXES];
      bit [sfh_pkg::TOTAL_WIDTH-1:0]  total;
      bit                             counted;
      int                             v;
      int                             p;
      int                             word;
      vals = '{x, y, z};
      if (op == sfh_pkg::OP_READ) begin
        total = '0;
        if (bin < sfh_pkg::DEF_BINS)
          for (int a = 0; a < sfh_pkg::DEF_AXES; a++) total += counts[a][bin];
        totals_q.push_back(total);
        return;
      end
      // first sample only primes; difference mode needs consecutive numbers
      counted = have_prev && (!diff_mode || number == prev_number + 1'b1);
      if (counted) begin
        for (int a = 0; a < sfh_pkg::DEF_AXES && a < sfh_pkg::FIELD_AXES; a++) begin
          v = int'($signed(vals[a]));
          p = int'($signed(prev_value[a]));
          if (whole_mode) begin
            bump(a, diff_mode ? ((v - p + 4096) & 'hFFF) : (v + 2048));
          end else begin
            word = diff_mode ? ((v - p + 4096) & 'hFFFF) : (v & 'hFFFF);
            bump(a, word & 'hFF);
            bump(a, (word >> 8) & 'hFF);
          end
        end
      end
      prev_value  = vals;
      prev_number = number;
      have_prev   = 1'b1;
    endfunction

    // Compare one bin total against the oldest prediction
    function void check_result(logic [sfh_pkg::TOTAL_WIDTH-1:0] got);
      bit [sfh_pkg::TOTAL_WIDTH-1:0] want;
      if (totals_q.size() == 0) begin
        errors++;
        $display("%0t: bin total with nothing pending: expected none, actual %0d",
                 $time, got);
      end else begin
        want = totals_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: bin total mismatch: expected %0d, actual %0d",
                   $time, want, got);
        end
      end
    endfunction
  endclass

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [sfh_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [sfh_pkg::CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                                s_tvalid  = 1'b0;
  logic                                s_tready;
  // s_tdata: sample_number[31:0], axis_x[43:32], axis_y[55:44],
  //          axis_z[67:56], bin_index[79:68]
  logic [sfh_pkg::DATA_WIDTH-1:0]      s_tdata   = '0;
  // s_tuser: operation[0]
  logic                                s_tuser   = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready  = 1'b0;
  // m_tdata: bin_total[31:0]
  logic [sfh_pkg::TOTAL_WIDTH-1:0]     m_tdata;

  hist_scoreboard                 hist;
  int                             gap_max     = 0;
  int                             burst_left  = 0;
  int                             idle_cycles = 0;
  rx_mode_t                       rx_mode     = RX_OPEN;
  int                             rx_left     = 0;
  bit [sfh_pkg::NUMBER_WIDTH-1:0] last_number = '0;
  bit [sfh_pkg::SAMPLE_WIDTH-1:0] cur_val[sfh_pkg::FIELD_AXES];

  symbol_frequency_histogram DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver: switches at random between stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
      RX_PULSE: m_tready <= rx_left[2];
      default:  m_tready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) hist.check_result(m_tdata);
  end

  // Watchdog on cycles with no transfer on either stream
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_symbol_frequency_histogram: done, errors");
      $finish;
    end
  end

  // Send one item, with a random gap at the start of each burst
  task automatic push_item(input logic op,
                           input logic [sfh_pkg::NUMBER_WIDTH-1:0] num,
                           input logic [sfh_pkg::SAMPLE_WIDTH-1:0] x,
                           input logic [sfh_pkg::SAMPLE_WIDTH-1:0] y,
                           input logic [sfh_pkg::SAMPLE_WIDTH-1:0] z,
                           input logic [sfh_pkg::BIN_WIDTH-1:0] bin);
    int gap;
    if (burst_left == 0) begin
      gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {bin, z, y, x, num};
    do @(posedge clk); while (!s_tready);
    hist.note_input(op, num, x, y, z, bin);
  endtask

  task automatic add_sample(input logic [sfh_pkg::NUMBER_WIDTH-1:0] num,
                            input logic [sfh_pkg::SAMPLE_WIDTH-1:0] x,
                            input logic [sfh_pkg::SAMPLE_WIDTH-1:0] y,
                            input logic [sfh_pkg::SAMPLE_WIDTH-1:0] z);
    push_item(sfh_pkg::OP_SAMPLE, num, x, y, z, 12'($urandom));
    last_number = num;
    cur_val     = '{x, y, z};
  endtask

  // Sample fields on a read are ignored, so they carry noise
  task automatic read_bin(input logic [sfh_pkg::BIN_WIDTH-1:0] bin);
    push_item(sfh_pkg::OP_READ, $urandom, 12'($urandom), 12'($urandom),
              12'($urandom), bin);
  endtask

  // Drain the block, then write both mode registers
  task automatic apply_modes(input bit diff, input bit whole);
    s_tvalid <= 1'b0;
    while (hist.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sfh_pkg::CFG_DIFFERENCE_MODE;
    cfg_data  <= diff;
    @(posedge clk);
    cfg_index <= sfh_pkg::CFG_WHOLE_SYMBOLS;
    cfg_data  <= whole;
    @(posedge clk);
    cfg_write <= 1'b0;
    hist.set_modes(diff, whole);
  endtask

  // Aim reads at bins that the current mode is likely to have filled
  function automatic logic [sfh_pkg::BIN_WIDTH-1:0] pick_bin(bit diff, bit whole);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'($urandom_range(0, sfh_pkg::DEF_BINS - 1));
    if (whole && !diff)
      return cur_val[$urandom_range(0, sfh_pkg::FIELD_AXES - 1)] + 12'd2048
             + 12'($urandom_range(0, 6) - 3);
    if (whole) return 12'($urandom_range(0, 16) - 8);
    if (r < 6) return 12'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return 12'h000;
      1:       return 12'h0FF;
      2:       return 12'h00F;
      default: return 12'h010;
    endcase
  endfunction

  // Hand-picked items: extremes, every mode, gaps and wraps of numbering
  task automatic run_directed();
    gap_max = 3;
    // byte symbols of raw values; the first sample only primes
    apply_modes(1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 12'h800, 12'h7FF, 12'h000);
    read_bin(12'h000);
    add_sample(32'h0000_0000, 12'h7FF, 12'h800, 12'hFFF);
    read_bin(12'h0FF);
    read_bin(12'h007);
    read_bin(12'h0F8);
    read_bin(12'h000);
    read_bin(12'hFFF);
    // whole differences, with a gap in numbering in the middle
    apply_modes(1'b1, 1'b1);
    add_sample(32'h0000_0001, 12'h7FF, 12'h800, 12'h005);
    add_sample(32'h0000_0007, 12'h000, 12'h000, 12'h000);
    add_sample(32'h0000_0008, 12'h800, 12'h7FF, 12'h001);
    read_bin(12'h000);
    read_bin(12'h800);
    read_bin(12'h7FF);
    read_bin(12'hFFF);
    // byte differences across the wrap of the sample number
    apply_modes(1'b1, 1'b0);
    add_sample(32'hFFFF_FFFF, 12'h001, 12'h002, 12'h003);
    add_sample(32'h0000_0000, 12'h800, 12'h7FF, 12'h003);
    read_bin(12'h010);
    read_bin(12'h0FF);
    // whole raw values
    apply_modes(1'b0, 1'b1);
    add_sample(32'h0000_007B, 12'h800, 12'h7FF, 12'h000);
    read_bin(12'h000);
    read_bin(12'hFFF);
    read_bin(12'h800);
  endtask

  // Mostly consecutive random walks, with reads, jumps and extremes mixed in
  task automatic run_phase(input int ph);
    bit                             diff;
    bit                             whole;
    int                             kind;
    int                             s;
    bit [sfh_pkg::SAMPLE_WIDTH-1:0] vals[sfh_pkg::FIELD_AXES];
    if (ph < 4) begin
      diff  = ph[0];
      whole = ph[1];
    end else begin
      diff  = 1'($urandom_range(0, 1));
      whole = 1'($urandom_range(0, 1));
    end
    gap_max = (ph == 2) ? 0 : $urandom_range(2, 8);
    apply_modes(diff, whole);
    repeat (PHASE_ITEMS) begin
      kind = $urandom_range(0, 99);
      vals = cur_val;
      if (kind < 22) begin
        read_bin(pick_bin(diff, whole));
      end else if (kind < 27) begin
        // jump in numbering with arbitrary values
        add_sample($urandom, 12'($urandom), 12'($urandom), 12'($urandom));
      end else if (kind < 29) begin
        // park just below the number wrap
        add_sample(32'hFFFF_FFFF - $urandom_range(0, 1), vals[0], vals[1], vals[2]);
      end else begin
        for (int a = 0; a < sfh_pkg::FIELD_AXES; a++) begin
          if (kind < 34) begin
            case ($urandom_range(0, 4))
              0:       vals[a] = 12'h800;
              1:       vals[a] = 12'h7FF;
              2:       vals[a] = 12'h000;
              3:       vals[a] = 12'hFFF;
              default: vals[a] = 12'($urandom);
            endcase
          end else begin
            s       = ($urandom_range(0, 7) == 0) ? 64 : 6;
            vals[a] = vals[a] + 12'($urandom_range(0, 2 * s) - s);
          end
        end
        add_sample(last_number + 1'b1, vals[0], vals[1], vals[2]);
      end
    end
  endtask

  initial begin
    hist    = new();
    cur_val = '{default: '0};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) run_phase(ph);
    s_tvalid <= 1'b0;
    while (hist.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hist.errors == 0 && hist.pending() == 0) begin
      $display("tb_symbol_frequency_histogram: done, clean");
    end else begin
      $display("tb_symbol_frequency_histogram: done, errors");
    end
    $finish;
  end

endmodule
